// ===== rtl/ccs_pkg.sv =====
// ccs_pkg: types and constants for the comment stripper core.
// Used by cpp_comment_stripper_core; no dependencies.
`timescale 1ns / 1ps

package ccs_pkg;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [1:0] {
		MODE_CODE  = 2'd0,
		MODE_LINE  = 2'd1,
		MODE_BLOCK = 2'd2
	} mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic       vld;
		logic       last;
	} res_t;

endpackage

// ===== rtl/cpp_comment_stripper_core.sv =====
// cpp_comment_stripper_core: streaming C++ comment remover / masker.
// Depends on ccs_pkg (mode_t, res_t, character constants).
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------
//   input    | in_valid / in_ready    | in_byte, in_last
//   result   | res_valid / res_ready  | out_byte, out_valid, out_last
//   config   | cfg_valid / cfg_ready  | cfg_data (repl_char)
//
// One input word is taken per cycle; it yields zero to two result words in
// the same cycle into a four-entry result buffer, drained one word a cycle while
// res_ready is high. in_ready drops while fewer than two buffer entries are free.
// Reset (arst_n low) clears mode, held delimiter, buffer and repl_char.
`timescale 1ns / 1ps

module cpp_comment_stripper_core
	import ccs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [7:0] out_byte,
	output logic       out_valid,
	output logic       out_last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	mode_t       mode_q, mode_d;
	logic        held_q, held_d;
	logic [7:0]  repl_q;

	res_t        buf_q [4];
	logic [1:0]  wr_q, rd_q;
	logic [2:0]  cnt_q;

	logic        in_acc, res_acc, rep_on;
	logic [1:0]  n;
	res_t        r [2];
	logic [7:0]  cm_byte;

	assign in_ready  = (cnt_q <= 3'd2);
	assign in_acc    = in_valid & in_ready;
	assign res_valid = (cnt_q != 3'd0);
	assign res_acc   = res_valid & res_ready;
	assign cfg_ready = 1'b1;
	assign rep_on    = (repl_q != 8'd0);

	assign out_byte  = buf_q[rd_q].data;
	assign out_valid = buf_q[rd_q].vld;
	assign out_last  = buf_q[rd_q].last;

	// comment byte: whitespace kept, everything else masked
	always_comb begin
		case (in_byte)
			CH_TAB, CH_NL, CH_SPACE: cm_byte = in_byte;
			default: cm_byte = repl_q;
		endcase
	end

	// next state
	always_comb begin
		mode_d = mode_q;
		held_d = held_q;
		case (mode_q)
			MODE_LINE: begin
				if (in_byte == CH_NL) mode_d = MODE_CODE;
			end
			MODE_BLOCK: begin
				if (held_q) begin
					if (in_byte == CH_SLASH) begin
						held_d = 1'b0;
						mode_d = MODE_CODE;
					end else if (in_byte != CH_STAR) begin
						held_d = 1'b0;
					end
				end else if (in_byte == CH_STAR) begin
					held_d = 1'b1;
				end
			end
			default: begin
				mode_d = MODE_CODE;
				if (held_q) begin
					held_d = 1'b0;
					if (in_byte == CH_SLASH) mode_d = MODE_LINE;
					else if (in_byte == CH_STAR) mode_d = MODE_BLOCK;
				end else if (in_byte == CH_SLASH) begin
					held_d = 1'b1;
				end
			end
		endcase
		if (in_last) begin
			held_d = 1'b0;
			mode_d = MODE_CODE;
		end
	end

	// result words
	always_comb begin
		logic fl_held;
		fl_held = 1'b0;
		n = 2'd0;
		r[0] = '{data: 8'd0, vld: 1'b0, last: 1'b0};
		r[1] = '{data: 8'd0, vld: 1'b0, last: 1'b0};
		case (mode_q)
			MODE_LINE: begin
				if (rep_on) begin
					r[0] = '{data: cm_byte, vld: 1'b1, last: 1'b0};
					n = 2'd1;
				end
			end
			MODE_BLOCK: begin
				if (held_q) begin
					if (in_byte == CH_SLASH) begin
						if (rep_on) begin
							r[0] = '{data: repl_q, vld: 1'b1, last: 1'b0};
							r[1] = '{data: repl_q, vld: 1'b1, last: 1'b0};
							n = 2'd2;
						end
					end else if (in_byte == CH_STAR) begin
						fl_held = 1'b1;
						if (rep_on) begin
							r[0] = '{data: repl_q, vld: 1'b1, last: 1'b0};
							n = 2'd1;
						end
					end else if (rep_on) begin
						r[0] = '{data: repl_q, vld: 1'b1, last: 1'b0};
						r[1] = '{data: cm_byte, vld: 1'b1, last: 1'b0};
						n = 2'd2;
					end
				end else if (in_byte == CH_STAR) begin
					fl_held = 1'b1;
				end else if (rep_on) begin
					r[0] = '{data: cm_byte, vld: 1'b1, last: 1'b0};
					n = 2'd1;
				end
			end
			default: begin
				if (held_q) begin
					if (in_byte inside {CH_SLASH, CH_STAR}) begin
						if (rep_on) begin
							r[0] = '{data: repl_q, vld: 1'b1, last: 1'b0};
							r[1] = '{data: repl_q, vld: 1'b1, last: 1'b0};
							n = 2'd2;
						end
					end else begin
						r[0] = '{data: CH_SLASH, vld: 1'b1, last: 1'b0};
						r[1] = '{data: in_byte, vld: 1'b1, last: 1'b0};
						n = 2'd2;
					end
				end else if (in_byte == CH_SLASH) begin
					r[0] = '{data: CH_SLASH, vld: 1'b0, last: 1'b0};
					fl_held = 1'b1;
				end else begin
					r[0] = '{data: in_byte, vld: 1'b1, last: 1'b0};
					n = 2'd1;
				end
			end
		endcase
		if (in_last) begin
			// flush a held delimiter: '*' in block comment, '/' in code
			if (fl_held) begin
				if (mode_q == MODE_BLOCK) begin
					if (rep_on) begin
						r[n[0]] = '{data: repl_q, vld: 1'b1, last: 1'b0};
						n = n + 2'd1;
					end
				end else begin
					r[0] = '{data: CH_SLASH, vld: 1'b1, last: 1'b0};
					n = 2'd1;
				end
			end
			if (n == 2'd0) begin
				r[0] = '{data: 8'd0, vld: 1'b0, last: 1'b0};
				n = 2'd1;
			end
			if (n == 2'd1) r[0].last = 1'b1;
			else r[1].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CODE;
			held_q <= 1'b0;
			repl_q <= 8'd0;
			wr_q   <= 2'd0;
			rd_q   <= 2'd0;
			cnt_q  <= 3'd0;
		end else begin
			if (cfg_valid) repl_q <= cfg_data;
			if (in_acc) begin
				mode_q <= mode_d;
				held_q <= held_d;
				wr_q   <= wr_q + n;
			end
			if (res_acc) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + (in_acc ? {1'b0, n} : 3'd0) - {2'd0, res_acc};
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (n != 2'd0) buf_q[wr_q] <= r[0];
			if (n == 2'd2) buf_q[wr_q + 2'd1] <= r[1];
		end
	end

endmodule

// ===== rtl/ccs_chk.sv =====
// ccs_chk: port-level checks for cpp_comment_stripper_core, bound below.
// Depends on nothing but the top level's ports.
`timescale 1ns / 1ps

module ccs_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] out_byte,
	input logic       out_valid,
	input logic       out_last
);

	// an empty word only ever closes a text
	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid |-> out_last && out_byte == 8'd0)
		else $error("empty result word without end mark");

	// input only stalls behind pending results
	a_stall_has_res: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> res_valid)
		else $error("input stalled with no result pending");

	// a stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(out_byte)
			&& $stable(out_valid) && $stable(out_last))
		else $error("stalled result word changed");

endmodule

bind cpp_comment_stripper_core ccs_chk u_ccs_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.out_byte  (out_byte),
	.out_valid (out_valid),
	.out_last  (out_last)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for cpp_comment_stripper_core.
// Depends on ccs_pkg and the core RTL. Drives source text, predicts every result
// word and checks each one in order under random stalls and several repl settings.

module testbench;
	import ccs_pkg::*;

	localparam int STALL_LIMIT   = 1000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_WORDS   = 270;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       in_last;
	logic       res_valid;
	logic       res_ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       out_last;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;

	// predictor state
	mode_t      cur_mode      = MODE_CODE;
	logic       pending_delim = 1'b0;
	logic [7:0] mask_byte     = 8'h00;

	res_t       stripped_q[$];
	res_t       head_word;
	logic [7:0] text_q[$];

	int tx_max      = 5;
	int rx_max      = 5;
	int errors      = 0;
	int words_in    = 0;
	int words_out   = 0;
	int cfg_writes  = 0;
	int idle_cycles = 0;

	cpp_comment_stripper_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.out_byte  (out_byte),
		.out_valid (out_valid),
		.out_last  (out_last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report(input string msg);
		errors++;
		if (errors <= 30) begin
			$display("ERROR at %0t: %s", $time, msg);
		end
	endtask

	task automatic push_word(input logic [7:0] b);
		res_t r;
		r.data = b;
		r.vld  = 1'b1;
		r.last = 1'b0;
		stripped_q = {stripped_q, r};
	endtask

	task automatic push_comment(input logic [7:0] b);
		if (mask_byte != 8'h00) begin
			if (b == CH_TAB || b == CH_NL || b == CH_SPACE) begin
				push_word(b);
			end else begin
				push_word(mask_byte);
			end
		end
	endtask

	task automatic push_delims();
		if (mask_byte != 8'h00) begin
			push_word(mask_byte);
			push_word(mask_byte);
		end
	endtask

	task automatic strip_byte(input logic [7:0] b, input logic last);
		int   base;
		res_t tail;
		base = stripped_q.size();
		case (cur_mode)
		MODE_LINE: begin
			if (b == CH_NL) begin
				cur_mode = MODE_CODE;
				if (mask_byte != 8'h00) begin
					push_word(CH_NL);
				end
			end else begin
				push_comment(b);
			end
		end
		MODE_BLOCK: begin
			if (pending_delim) begin
				if (b == CH_SLASH) begin
					pending_delim = 1'b0;
					cur_mode      = MODE_CODE;
					push_delims();
				end else begin
					push_comment(CH_STAR);
					if (b != CH_STAR) begin
						pending_delim = 1'b0;
						push_comment(b);
					end
				end
			end else if (b == CH_STAR) begin
				pending_delim = 1'b1;
			end else begin
				push_comment(b);
			end
		end
		default: begin
			cur_mode = MODE_CODE;
			if (pending_delim) begin
				pending_delim = 1'b0;
				if (b == CH_SLASH) begin
					cur_mode = MODE_LINE;
					push_delims();
				end else if (b == CH_STAR) begin
					cur_mode = MODE_BLOCK;
					push_delims();
				end else begin
					push_word(CH_SLASH);
					push_word(b);
				end
			end else if (b == CH_SLASH) begin
				pending_delim = 1'b1;
			end else begin
				push_word(b);
			end
		end
		endcase
		if (last) begin
			if (pending_delim) begin
				if (cur_mode == MODE_BLOCK) begin
					push_comment(CH_STAR);
				end else begin
					push_word(CH_SLASH);
				end
			end
			pending_delim = 1'b0;
			cur_mode      = MODE_CODE;
			if (stripped_q.size() == base) begin
				tail = '0;
				stripped_q = {stripped_q, tail};
			end
			tail      = stripped_q[stripped_q.size() - 1];
			tail.last = 1'b1;
			stripped_q[stripped_q.size() - 1] = tail;
		end
	endtask

	// prediction, result check and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				mask_byte = cfg_data;
				cfg_writes++;
			end
			if (in_valid && in_ready) begin
				strip_byte(in_byte, in_last);
			end
			if (res_valid && res_ready) begin
				words_out++;
				if (stripped_q.size() == 0) begin
					report($sformatf("unexpected word %h valid %b last %b",
						out_byte, out_valid, out_last));
				end else begin
					head_word = stripped_q.pop_front();
					if (out_byte !== head_word.data) begin
						report($sformatf("word %0d: out_byte %h, expected %h",
							words_out, out_byte, head_word.data));
					end
					if (out_valid !== head_word.vld) begin
						report($sformatf("word %0d: out_valid %b, expected %b",
							words_out, out_valid, head_word.vld));
					end
					if (out_last !== head_word.last) begin
						report($sformatf("word %0d: out_last %b, expected %b",
							words_out, out_last, head_word.last));
					end
				end
			end
			if ((in_valid && in_ready) || (res_valid && res_ready) ||
				(cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
				$display("testbench failed");
				$finish;
			end
		end
	end

	// result side: random stall before each word
	initial begin
		int n;
		res_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			n = $urandom_range(rx_max);
			if (n != 0) begin
				res_ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
			@(negedge clk);
		end
	end

	// called at a falling edge; returns at a falling edge with in_valid still high
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = $urandom_range(tx_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= last;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		words_in++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (stripped_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_repl(input logic [7:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_char();
		case ($urandom_range(9))
		0, 1, 2, 3: return 8'($urandom);
		4: return CH_SLASH;
		5: return CH_STAR;
		6: return CH_NL;
		7: return CH_TAB;
		8: return CH_SPACE;
		default: return 8'h61 + 8'($urandom_range(25));
		endcase
	endfunction

	task automatic add_char(input logic [7:0] c);
		text_q = {text_q, c};
	endtask

	task automatic build_text(input int pieces, input logic noise);
		text_q.delete();
		repeat (pieces) begin
			if (noise) begin
				add_char(8'($urandom));
			end else begin
				case ($urandom_range(5))
				0: begin
					add_char(CH_SLASH);
					add_char(CH_SLASH);
					repeat ($urandom_range(6)) add_char(pick_char());
					if ($urandom_range(3) != 0) begin
						add_char(CH_NL);
					end
				end
				1: begin
					add_char(CH_SLASH);
					add_char(CH_STAR);
					repeat ($urandom_range(8)) add_char(pick_char());
					if ($urandom_range(3) != 0) begin
						if ($urandom_range(1)) begin
							add_char(CH_STAR);
						end
						add_char(CH_STAR);
						add_char(CH_SLASH);
					end
				end
				2: begin
					add_char(CH_SLASH);
					add_char(pick_char());
				end
				3, 4: begin
					repeat ($urandom_range(4, 1)) add_char(pick_char());
				end
				default: begin
					add_char(8'($urandom));
				end
				endcase
			end
		end
	endtask

	task automatic send_text();
		foreach (text_q[i]) begin
			send_byte(text_q[i], i == text_q.size() - 1);
		end
	endtask

	// reset value of repl: comments deleted
	task automatic test_delete_mode();
		send_byte(8'h00, 1'b0);
		send_byte(CH_SLASH, 1'b0);
		send_byte("x", 1'b0);
		send_byte(CH_SLASH, 1'b0);
		send_byte(CH_SLASH, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_NL, 1'b0);
		send_byte(CH_SLASH, 1'b0);
		send_byte(CH_STAR, 1'b0);
		send_byte(CH_STAR, 1'b0);
		send_byte(CH_STAR, 1'b0);
		send_byte(CH_SLASH, 1'b0);
		send_byte(CH_SLASH, 1'b1);
		send_byte(CH_SLASH, 1'b0);
		send_byte(CH_SLASH, 1'b1);
	endtask

	task automatic test_mask_mode();
		write_repl(8'hFF);
		send_byte(CH_SLASH, 1'b0);
		send_byte(CH_STAR, 1'b0);
		send_byte(CH_TAB, 1'b0);
		send_byte("a", 1'b0);
		send_byte(CH_STAR, 1'b0);
		send_byte(CH_SPACE, 1'b0);
		send_byte(CH_STAR, 1'b1);
		send_byte(CH_SLASH, 1'b0);
		send_byte(CH_SLASH, 1'b0);
		send_byte("z", 1'b1);
	endtask

	task automatic test_random_phase(input logic [7:0] repl, input int tx, input int rx,
		input int n_words);
		int   target;
		logic paused;
		write_repl(repl);
		tx_max = tx;
		rx_max = rx;
		target = words_in + n_words;
		paused = 1'b0;
		while (words_in < target) begin
			build_text($urandom_range(8, 1), $urandom_range(4) == 0);
			send_text();
			if (!paused && words_in >= target - n_words / 2) begin
				wait_drained();
				paused = 1'b1;
			end else if ($urandom_range(19) == 0) begin
				wait_drained();
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_byte   = 8'h00;
		in_last   = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = 8'h00;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_delete_mode();
		test_mask_mode();
		test_random_phase(8'h00, 0, 0, PHASE_WORDS);
		test_random_phase(8'h01, 5, 5, PHASE_WORDS);
		test_random_phase(8'hFF, 5, 0, PHASE_WORDS);
		test_random_phase(8'h23, 0, 5, PHASE_WORDS);
		test_random_phase(8'($urandom_range(255, 1)), 5, 5, PHASE_WORDS);
		test_random_phase(8'h00, 5, 5, PHASE_WORDS);

		wait_drained();
		$display("%0d source words sent, %0d result words checked, %0d repl writes",
			words_in, words_out, cfg_writes);
		$display("covered delete and mask modes, line and block comments, held delimiters");
		if (errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
